FILE: rtl/gct_pkg.sv
// Shared types and constants for the genotype call tally block.
// Holds call codes, opcodes, register indexes, tally layout and FSM states.
// No dependencies.
package gct_pkg;

  // Call codes
  typedef enum logic [2:0] {
    CALL_NA = 3'd0,
    CALL_NC = 3'd1,
    CALL_AA = 3'd2,
    CALL_BB = 3'd3,
    CALL_AB = 3'd4
  } call_t;

  localparam int NUM_KINDS   = 5;
  localparam int OWN_BASE    = 0;
  localparam int REF_BASE    = OWN_BASE + NUM_KINDS;
  localparam int PAIR_BASE   = REF_BASE + NUM_KINDS;
  localparam int TALLY_DEPTH = PAIR_BASE + NUM_KINDS * NUM_KINDS;
  localparam int TALLY_AW    = $clog2(TALLY_DEPTH);

  // Three counters are bumped for every counted probe
  localparam int NUM_TALLIES = 3;
  localparam logic [1:0] LAST_STEP = 2'(NUM_TALLIES - 1);

  // Opcodes carried on tuser
  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Field widths fixed by the item format
  localparam int FRAC_W  = 16;
  localparam int BEADS_W = 8;
  localparam int CALL_W  = 3;
  localparam int INDEX_W = 6;
  localparam int READ_W  = 32;
  localparam int SNR_W   = 8;
  localparam int THR_W   = 16;

  // Input tdata bits that do not scale with the signal width
  localparam int IN_FIXED_W = FRAC_W + 2 + 2 * BEADS_W + CALL_W + INDEX_W;
  localparam int OUT_DATA_W = ((CALL_W + 1 + READ_W + 7) / 8) * 8;

  // Configuration registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_CUTOFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SIGNAL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SNR        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SD_LIMIT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BEADS      = 3'd4;
  localparam logic [FRAC_W-1:0]    BALANCE_CUTOFF_RST = 16'd768;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_INC,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/gct_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module gct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 35,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/genotype_call_tally_core.sv
// Genotype caller with own, reference and pair call tallies held in one RAM.
// Depends on gct_pkg and gct_ram.
//
// Channel  | Direction | Handshake          | Carries
// ---------+-----------+--------------------+-----------------------------------------
// in_      | slave     | in_tvalid/tready   | probe or counter read request
// out_     | master    | out_tvalid/tready  | call, counted flag, counter value
// cfg_     | write     | cfg_we             | thresholds by register index
//
// Sequencing: one request at a time, sequenced around a single RAM port pair.
//   A counted probe runs EXEC (classify), then three read-modify-writes in INC,
//   serial through the one write port and overlapped on the RAM, then DONE (result).
//   A counter read runs EXEC, RDWAIT and DONE; a missing-signal probe EXEC and DONE.
// Reset: rst_n synchronous, active low. Counters read as zero until first
//   written, through a valid bit per RAM entry; no clearing pass is needed.
// Stalls: a finished result waits in DONE until the output register is free;
//   the output register holds one result while the next request is taken.
module genotype_call_tally_core #(
  parameter int COUNT_WIDTH  = 32,
  parameter int SIGNAL_WIDTH = 16,
  localparam int IN_DATA_W = ((gct_pkg::IN_FIXED_W + 4 * SIGNAL_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata, lowest bit up: balance_frac, signal_a, signal_b, missing_a, missing_b,
  //   spread_a, spread_b, beads_a, beads_b, reference_call, counter_index, zero fill
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_DATA_W-1:0]            in_tdata,
  // in_tuser: opcode
  input  logic                            in_tuser,
  // out_tdata, lowest bit up: call, counted, read_value, zero fill
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gct_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_we,
  input  logic [gct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gct_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import gct_pkg::*;

  localparam int SW     = SIGNAL_WIDTH;
  localparam int CMP_W  = (SW > THR_W) ? SW : THR_W;
  localparam int PROD_W = SNR_W + SW;

  // tdata field offsets
  localparam int OFF_SIG_A   = FRAC_W;
  localparam int OFF_SIG_B   = OFF_SIG_A + SW;
  localparam int OFF_MISS_A  = OFF_SIG_B + SW;
  localparam int OFF_MISS_B  = OFF_MISS_A + 1;
  localparam int OFF_SPR_A   = OFF_MISS_B + 1;
  localparam int OFF_SPR_B   = OFF_SPR_A + SW;
  localparam int OFF_BEADS_A = OFF_SPR_B + SW;
  localparam int OFF_BEADS_B = OFF_BEADS_A + BEADS_W;
  localparam int OFF_REF     = OFF_BEADS_B + BEADS_W;
  localparam int OFF_IDX     = OFF_REF + CALL_W;

  // Configuration registers
  logic [FRAC_W-1:0] balance_cutoff_r;
  logic [THR_W-1:0]  min_signal_r;
  logic [SNR_W-1:0]  min_snr_r;
  logic [THR_W-1:0]  sd_limit_r;
  logic [BEADS_W-1:0] min_beads_r;

  // Request registers
  logic               op_r;
  logic [FRAC_W-1:0]  frac_r;
  logic [SW-1:0]      sig_a_r, sig_b_r;
  logic               miss_a_r, miss_b_r;
  logic [SW-1:0]      spr_a_r, spr_b_r;
  logic [BEADS_W-1:0] beads_a_r, beads_b_r;
  logic [CALL_W-1:0]  ref_r;
  logic [INDEX_W-1:0] idx_r;
  logic [PROD_W-1:0]  prod_a_r, prod_b_r;

  // Sequencer
  state_t                state_r, state_nxt;
  logic [1:0]            step_r, step_nxt;
  call_t                 own_r, own_nxt;
  logic [TALLY_AW-1:0]   ref_addr_r, ref_addr_nxt;
  logic [TALLY_AW-1:0]   pair_addr_r, pair_addr_nxt;
  logic [TALLY_DEPTH-1:0] valid_r;
  logic                  rd_hit_r, rd_hit_nxt;
  logic                  rd_ok;

  // Result
  call_t             res_call_r, res_call_nxt;
  logic              res_counted_r, res_counted_nxt;
  logic [READ_W-1:0] res_value_r, res_value_nxt;
  logic              out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic              out_load;

  // RAM port
  logic                   ram_we;
  logic [TALLY_AW-1:0]    ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [COUNT_WIDTH-1:0] cnt_eff;

  // Classification
  logic                is_ab, snr_a_bad, snr_b_bad, snr_bad;
  logic [SW-1:0]       sig_sel, sd_sel;
  logic [BEADS_W-1:0]  beads_sel;
  call_t               base_call, own_call;
  logic [CALL_W-1:0]   ref_code;
  logic [TALLY_AW-1:0] own_addr, ref_addr, pair_addr, step_addr, next_addr;
  logic                idx_in_range;

  logic in_accept;
  assign in_accept = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      balance_cutoff_r <= BALANCE_CUTOFF_RST;
      min_signal_r     <= '0;
      min_snr_r        <= '0;
      sd_limit_r       <= '0;
      min_beads_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BALANCE_CUTOFF: balance_cutoff_r <= cfg_data[FRAC_W-1:0];
        REG_MIN_SIGNAL:     min_signal_r     <= cfg_data[THR_W-1:0];
        REG_MIN_SNR:        min_snr_r        <= cfg_data[SNR_W-1:0];
        REG_SD_LIMIT:       sd_limit_r       <= cfg_data[THR_W-1:0];
        REG_MIN_BEADS:      min_beads_r      <= cfg_data[BEADS_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request; form the SNR products straight away
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r      <= in_tuser;
      frac_r    <= in_tdata[0 +: FRAC_W];
      sig_a_r   <= in_tdata[OFF_SIG_A +: SW];
      sig_b_r   <= in_tdata[OFF_SIG_B +: SW];
      miss_a_r  <= in_tdata[OFF_MISS_A];
      miss_b_r  <= in_tdata[OFF_MISS_B];
      spr_a_r   <= in_tdata[OFF_SPR_A +: SW];
      spr_b_r   <= in_tdata[OFF_SPR_B +: SW];
      beads_a_r <= in_tdata[OFF_BEADS_A +: BEADS_W];
      beads_b_r <= in_tdata[OFF_BEADS_B +: BEADS_W];
      ref_r     <= in_tdata[OFF_REF +: CALL_W];
      idx_r     <= in_tdata[OFF_IDX +: INDEX_W];
      prod_a_r  <= PROD_W'(min_snr_r) * PROD_W'(in_tdata[OFF_SPR_A +: SW]);
      prod_b_r  <= PROD_W'(min_snr_r) * PROD_W'(in_tdata[OFF_SPR_B +: SW]);
    end
  end

  // Call the probe: balance first, then the quality gates in priority order
  always_comb begin
    is_ab     = (frac_r < balance_cutoff_r);
    snr_a_bad = (spr_a_r != '0) && (PROD_W'(sig_a_r) < prod_a_r);
    snr_b_bad = (spr_b_r != '0) && (PROD_W'(sig_b_r) < prod_b_r);
    if (is_ab) begin
      base_call = CALL_AB;
      sig_sel   = (sig_a_r < sig_b_r) ? sig_a_r : sig_b_r;
      sd_sel    = (spr_a_r > spr_b_r) ? spr_a_r : spr_b_r;
      beads_sel = (beads_a_r < beads_b_r) ? beads_a_r : beads_b_r;
      snr_bad   = snr_a_bad || snr_b_bad;
    end else if (sig_a_r >= sig_b_r) begin
      base_call = CALL_AA;
      sig_sel   = sig_a_r;
      sd_sel    = spr_a_r;
      beads_sel = beads_a_r;
      snr_bad   = snr_a_bad;
    end else begin
      base_call = CALL_BB;
      sig_sel   = sig_b_r;
      sd_sel    = spr_b_r;
      beads_sel = beads_b_r;
      snr_bad   = snr_b_bad;
    end

    own_call = base_call;
    if ((min_signal_r != '0) && (CMP_W'(sig_sel) < CMP_W'(min_signal_r))) begin
      own_call = CALL_NC;
    end else if ((min_snr_r != '0) && snr_bad) begin
      own_call = CALL_NC;
    end else if ((sd_limit_r != '0) && (CMP_W'(sd_sel) < CMP_W'(sd_limit_r))) begin
      own_call = CALL_NC;
    end else if ((min_beads_r != '0) && (beads_sel < min_beads_r)) begin
      own_call = CALL_NC;
    end

    // Reference codes beyond AB tally as NA
    ref_code  = (ref_r > CALL_W'(CALL_AB)) ? CALL_W'(CALL_NA) : ref_r;
    own_addr  = TALLY_AW'(OWN_BASE) + TALLY_AW'(own_call);
    ref_addr  = TALLY_AW'(REF_BASE) + TALLY_AW'(ref_code);
    pair_addr = TALLY_AW'(PAIR_BASE) + TALLY_AW'(own_call) * TALLY_AW'(NUM_KINDS)
              + TALLY_AW'(ref_code);
    idx_in_range = (TALLY_AW'(idx_r) < TALLY_AW'(TALLY_DEPTH)) &&
                   (idx_r < INDEX_W'(TALLY_DEPTH));
  end

  // Address of the counter written in this step, and of the one read next
  always_comb begin
    case (step_r)
      2'd0:    step_addr = TALLY_AW'(OWN_BASE) + TALLY_AW'(own_r);
      2'd1:    step_addr = ref_addr_r;
      default: step_addr = pair_addr_r;
    endcase
    case (step_r)
      2'd0:    next_addr = ref_addr_r;
      default: next_addr = pair_addr_r;
    endcase
  end

  // Entries never written read as zero
  assign cnt_eff = rd_hit_r ? ram_rdata : '0;

  // Next state, RAM controls and result
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    own_nxt         = own_r;
    ref_addr_nxt    = ref_addr_r;
    pair_addr_nxt   = pair_addr_r;
    res_call_nxt    = res_call_r;
    res_counted_nxt = res_counted_r;
    res_value_nxt   = res_value_r;
    ram_we          = 1'b0;
    ram_waddr       = step_addr;
    ram_wdata       = cnt_eff + COUNT_WIDTH'(1);
    ram_raddr       = next_addr;
    rd_ok           = 1'b1;
    out_load        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_call_nxt    = CALL_NA;
        res_counted_nxt = 1'b0;
        res_value_nxt   = '0;
        if (op_r == OP_READ) begin
          // Out-of-range indices read as zero
          ram_raddr = idx_in_range ? idx_r[TALLY_AW-1:0] : '0;
          rd_ok     = idx_in_range;
          state_nxt = ST_RDWAIT;
        end else if (miss_a_r || miss_b_r) begin
          state_nxt = ST_DONE;
        end else begin
          // Issue the own-call counter read and hold the other two addresses
          ram_raddr     = own_addr;
          own_nxt       = own_call;
          ref_addr_nxt  = ref_addr;
          pair_addr_nxt = pair_addr;
          step_nxt      = '0;
          state_nxt     = ST_INC;
        end
      end
      ST_RDWAIT: begin
        res_value_nxt = READ_W'(cnt_eff);
        state_nxt     = ST_DONE;
      end
      ST_INC: begin
        // Write back this counter while the next one is read
        ram_we = 1'b1;
        if (step_r == LAST_STEP) begin
          res_call_nxt    = own_r;
          res_counted_nxt = 1'b1;
          state_nxt       = ST_DONE;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    rd_hit_nxt = rd_ok && valid_r[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r        <= step_nxt;
    own_r         <= own_nxt;
    ref_addr_r    <= ref_addr_nxt;
    pair_addr_r   <= pair_addr_nxt;
    rd_hit_r      <= rd_hit_nxt;
    res_call_r    <= res_call_nxt;
    res_counted_r <= res_counted_nxt;
    res_value_r   <= res_value_nxt;
    if (out_load) begin
      out_tdata_r <= OUT_DATA_W'({res_value_r, res_counted_r, res_call_r});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // All 35 counters in one RAM: own, then reference, then pair
  gct_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (TALLY_DEPTH)
  ) u_tally_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
